// File: hdl/deq_pkg.sv
// Package for the double-ended queue: request, response and command types,
// request codes and status codes. No dependencies.
package deq_pkg;

    localparam logic [1:0] REQ_PUSH_BACK  = 2'd0;
    localparam logic [1:0] REQ_POP_BACK   = 2'd1;
    localparam logic [1:0] REQ_PUSH_FRONT = 2'd2;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd3;

    localparam logic [1:0] STS_DONE       = 2'd0;
    localparam logic [1:0] STS_EMPTY      = 2'd1;
    localparam logic [1:0] STS_FULL       = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] push_value;
    } deq_req_t;

    typedef struct packed {
        logic [31:0] pop_value;
        logic [1:0]  status;
        logic [4:0]  occupancy;
    } deq_rsp_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } deq_cmd_t;

endpackage

// File: hdl/deq_ctrl.sv
// Controller for the double-ended queue: sequences capture, execute and
// response of one request. Depends on deq_pkg.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output deq_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg <= ST_RESP;
                end
                ST_RESP: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_RESP);
    assign cmd.capture = s_ready && s_valid;
    assign cmd.execute = (state_reg == ST_EXEC);

endmodule

// File: hdl/deq_dpath.sv
// Datapath for the double-ended queue: request register, ring pointers,
// entry count, entry memory and response registers. Depends on deq_pkg.
module deq_dpath
    import deq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  deq_cmd_t cmd,
    input  deq_req_t s_req,
    output deq_rsp_t m_rsp
);

    localparam int PW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SB = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam logic [PW-1:0] PTR_LAST = PW'(CAPACITY - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);

    logic [SB-1:0] mem [CAPACITY];

    deq_req_t      req_reg;
    logic [PW-1:0] front_reg;
    logic [PW-1:0] front_next;
    logic [PW-1:0] back_reg;
    logic [PW-1:0] back_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic          pop_ok_reg;
    logic          pop_ok_next;
    logic [SB-1:0] rd_data_reg;

    logic [PW-1:0] front_inc;
    logic [PW-1:0] front_dec;
    logic [PW-1:0] back_inc;
    logic [PW-1:0] back_dec;
    logic [PW-1:0] mem_addr;
    logic          mem_we;
    logic          mem_re;
    logic          is_empty;
    logic          is_full;

    assign front_inc = (front_reg == PTR_LAST) ? '0 : front_reg + PW'(1);
    assign front_dec = (front_reg == '0) ? PTR_LAST : front_reg - PW'(1);
    assign back_inc  = (back_reg == PTR_LAST) ? '0 : back_reg + PW'(1);
    assign back_dec  = (back_reg == '0) ? PTR_LAST : back_reg - PW'(1);
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_FULL);

    always_comb begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = STS_DONE;
        pop_ok_next = 1'b0;
        mem_addr    = back_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        unique case (req_reg.req_type)
            REQ_PUSH_BACK: begin
                mem_addr = back_reg;
                if (is_full) begin
                    status_next = STS_FULL;
                end else begin
                    mem_we     = 1'b1;
                    back_next  = back_inc;
                    count_next = count_reg + CW'(1);
                end
            end
            REQ_POP_BACK: begin
                mem_addr = back_dec;
                if (is_empty) begin
                    status_next = STS_EMPTY;
                end else begin
                    mem_re      = 1'b1;
                    pop_ok_next = 1'b1;
                    back_next   = back_dec;
                    count_next  = count_reg - CW'(1);
                end
            end
            REQ_PUSH_FRONT: begin
                mem_addr = front_dec;
                if (is_full) begin
                    status_next = STS_FULL;
                end else begin
                    mem_we     = 1'b1;
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            REQ_POP_FRONT: begin
                mem_addr = front_reg;
                if (is_empty) begin
                    status_next = STS_EMPTY;
                end else begin
                    mem_re      = 1'b1;
                    pop_ok_next = 1'b1;
                    front_next  = front_inc;
                    count_next  = count_reg - CW'(1);
                end
            end
            default: begin
                mem_addr = back_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_req;
        end
        if (cmd.execute) begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg  <= '0;
            back_reg   <= '0;
            count_reg  <= '0;
            pop_ok_reg <= 1'b0;
        end else if (cmd.execute) begin
            front_reg  <= front_next;
            back_reg   <= back_next;
            count_reg  <= count_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    // single-port entry store, registered read
    always_ff @(posedge aclk) begin
        if (cmd.execute && mem_we) begin
            mem[mem_addr] <= req_reg.push_value[SB-1:0];
        end
        if (cmd.execute && mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign m_rsp.pop_value = pop_ok_reg ? 32'(rd_data_reg) : 32'd0;
    assign m_rsp.status    = status_reg;
    assign m_rsp.occupancy = 5'(count_reg);

endmodule

// File: hdl/double_ended_queue.sv
// Top level of the double-ended queue: joins controller and datapath.
// Depends on deq_pkg, deq_ctrl and deq_dpath.
//
// Fixed-capacity double-ended queue kept as a ring of CAPACITY entries of
// VALUE_BITS bits (at most 32 are kept). Each request pushes or pops at the
// back or the front and yields one response carrying the popped value (zero
// unless a pop succeeds), a status (done, pop on empty, push on full) and the
// occupancy afterwards. Error requests leave the queue unchanged. One request
// is handled at a time: it is taken in the idle state, executed against the
// single-port entry memory in the execute state, and its response is offered
// in the response state until accepted; only then is a new request taken.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  deq_req_t s_req,
    output logic     m_valid,
    input  logic     m_ready,
    output deq_rsp_t m_rsp
);

    deq_cmd_t cmd;

    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    deq_dpath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_req   (s_req),
        .m_rsp   (m_rsp)
    );

endmodule

// File: dv/double_ended_queue_test.sv
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue: random and directed requests with
// a scoreboard that tracks the ring contents. Depends on deq_pkg and the RTL.
module double_ended_queue_test;
    import deq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_REQS = 950;

    class deque_scoreboard;
        logic [31:0] ring [DEPTH];
        bit [3:0]    head;
        bit [3:0]    tail;
        int unsigned held;
        deq_rsp_t    pending_rsp [$];
        int          errors;

        function void take_request(deq_req_t r);
            deq_rsp_t rsp;
            rsp = '0;
            rsp.status = STS_DONE;
            case (r.req_type)
                REQ_PUSH_BACK: begin
                    if (held == DEPTH) begin
                        rsp.status = STS_FULL;
                    end else begin
                        ring[tail] = r.push_value;
                        tail++;
                        held++;
                    end
                end
                REQ_PUSH_FRONT: begin
                    if (held == DEPTH) begin
                        rsp.status = STS_FULL;
                    end else begin
                        head--;
                        ring[head] = r.push_value;
                        held++;
                    end
                end
                REQ_POP_BACK: begin
                    if (held == 0) begin
                        rsp.status = STS_EMPTY;
                    end else begin
                        tail--;
                        rsp.pop_value = ring[tail];
                        held--;
                    end
                end
                REQ_POP_FRONT: begin
                    if (held == 0) begin
                        rsp.status = STS_EMPTY;
                    end else begin
                        rsp.pop_value = ring[head];
                        head++;
                        held--;
                    end
                end
            endcase
            rsp.occupancy = 5'(held);
            pending_rsp = {pending_rsp, rsp};
        endfunction

        function void match_response(deq_rsp_t got);
            deq_rsp_t want;
            if (pending_rsp.size() == 0) begin
                errors++;
                $display("%0t: unexpected response, expected none, actual %h", $time, got);
                return;
            end
            want = pending_rsp.pop_front();
            if (got.pop_value !== want.pop_value) begin
                errors++;
                $display("%0t: pop_value expected %h actual %h",
                         $time, want.pop_value, got.pop_value);
            end
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            end
            if (got.occupancy !== want.occupancy) begin
                errors++;
                $display("%0t: occupancy expected %0d actual %0d",
                         $time, want.occupancy, got.occupancy);
            end
        endfunction

        function int outstanding();
            return pending_rsp.size();
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    deq_req_t s_req = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    deq_rsp_t m_rsp;

    bit              idling_on = 1'b1;
    int unsigned     quiet_cycles = 0;
    deque_scoreboard sb = new();

    double_ended_queue uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready = !(idling_on && $urandom_range(99) < 10);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.take_request(s_req);
            end
            if (m_valid && m_ready) begin
                sb.match_response(m_rsp);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [31:0] draw_value();
        int unsigned k;
        k = $urandom_range(31);
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'd1 << k;
            3: return ~(32'd1 << k);
            default: return $urandom();
        endcase
    endfunction

    // push_pct: share of pushes, steering the queue towards full or empty
    function automatic deq_req_t draw_request(int unsigned push_pct);
        deq_req_t r;
        r.push_value = draw_value();
        if ($urandom_range(99) < push_pct) begin
            r.req_type = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        end else begin
            r.req_type = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
        end
        return r;
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [31:0] value);
        while (idling_on && $urandom_range(99) < 10) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_req.req_type = kind;
        s_req.push_value = value;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic run_directed();
        send_request(REQ_POP_BACK, 32'h1234_5678);
        send_request(REQ_POP_FRONT, '1);
        send_request(REQ_PUSH_BACK, '1);
        send_request(REQ_PUSH_FRONT, '0);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_POP_FRONT, '0);
        // fill to capacity from both ends, wrapping the front pointer
        for (int i = 0; i < DEPTH; i++) begin
            send_request(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, draw_value());
        end
        send_request(REQ_PUSH_BACK, 32'hA5A5_A5A5);
        send_request(REQ_PUSH_FRONT, 32'h5A5A_5A5A);
    endtask

    task automatic run_random();
        deq_req_t    r;
        int unsigned push_pct;
        int unsigned phase_left;
        phase_left = 0;
        push_pct = 50;
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(60, 25);
                case ($urandom_range(4))
                    0: push_pct = 95;
                    1: push_pct = 75;
                    2: push_pct = 50;
                    3: push_pct = 25;
                    default: push_pct = 5;
                endcase
            end
            phase_left--;
            idling_on = !(i >= 400 && i < 560);
            r = draw_request(push_pct);
            send_request(r.req_type, r.push_value);
        end
        idling_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        run_directed();
        run_random();
        s_valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
